/* hdl/media_frame_decoder_validator_assert.svh */
// Assertion macros shared by the media frame decoder and validator.
`ifndef MEDIA_FRAME_DECODER_VALIDATOR_ASSERT_SVH
`define MEDIA_FRAME_DECODER_VALIDATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MFDV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mfdv assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define MFDV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfdv assertion failed");

`endif

/* hdl/mfdv_pkg.sv */
// Package: shared types and constants of the media frame decoder and validator.
package mfdv_pkg;

  localparam int unsigned TYPE_W     = 8;
  localparam int unsigned COUNTER_W  = 32;
  localparam int unsigned LEN_FIELD_W = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Header is one type byte plus four counter bytes.
  localparam logic [2:0] HDR_BYTES = 3'd5;

  // JPEG start and end markers.
  localparam logic [7:0] JPEG_MARK  = 8'hFF;
  localparam logic [7:0] JPEG_SOI   = 8'hD8;
  localparam logic [15:0] JPEG_EOI_WORD = 16'hFFD9;
  localparam logic [2:0] JPEG_MIN_LEN = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIC_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_TYPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPK_TYPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JPEG_MAX  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_LEN_ERR = 2'd2,
    ST_FMT_ERR = 2'd3
  } status_e;

  typedef struct packed {
    logic [TYPE_W-1:0]      mic_type;
    logic [TYPE_W-1:0]      cam_type;
    logic [TYPE_W-1:0]      spk_type;
    logic [LEN_FIELD_W-1:0] audio_len;
    logic [LEN_FIELD_W-1:0] jpeg_max;
  } cfg_t;

  // Marker evidence gathered over the payload.
  typedef struct packed {
    logic [1:0]  start_ok;
    logic [15:0] last_two;
    logic        len_ovf;
  } marks_t;

endpackage

/* hdl/mfdv_classify.sv */
// Frame classifier: type match and status from the collected frame summary.
module mfdv_classify
  import mfdv_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 20
) (
  input  cfg_t                   cfg_i,
  input  logic [TYPE_W-1:0]      frame_type_i,
  input  logic [LENGTH_BITS-1:0] len_i,
  input  marks_t                 marks_i,
  output logic                   type_known_o,
  output status_e                status_o
);

  localparam int unsigned CmpW = (LENGTH_BITS > LEN_FIELD_W) ? LENGTH_BITS : LEN_FIELD_W;

  logic [CmpW-1:0] len_w;
  logic [CmpW-1:0] audio_w;
  logic [CmpW-1:0] jpeg_w;
  logic            is_audio;
  logic            is_cam;
  logic            jpeg_fmt_ok;

  assign len_w   = CmpW'(len_i);
  assign audio_w = CmpW'(cfg_i.audio_len);
  assign jpeg_w  = CmpW'(cfg_i.jpeg_max);

  assign is_audio = (frame_type_i == cfg_i.mic_type) || (frame_type_i == cfg_i.spk_type);
  assign is_cam   = (frame_type_i == cfg_i.cam_type);
  assign type_known_o = is_audio || is_cam;

  assign jpeg_fmt_ok = (len_w >= CmpW'(JPEG_MIN_LEN)) && (marks_i.start_ok == 2'b11) &&
                       (marks_i.last_two == JPEG_EOI_WORD);

  // Audio wins over camera when codes collide.
  always_comb begin
    status_o = ST_OK;
    if (marks_i.len_ovf) begin
      status_o = ST_LEN_ERR;
    end else if (is_audio) begin
      status_o = (len_w == audio_w) ? ST_OK : ST_LEN_ERR;
    end else if (is_cam) begin
      if (len_w > jpeg_w) begin
        status_o = ST_LEN_ERR;
      end else if (!jpeg_fmt_ok) begin
        status_o = ST_FMT_ERR;
      end
    end
  end

endmodule

/* hdl/media_frame_decoder_validator.sv */
// Top level: byte-stream frame header decoder and payload validator.
// Latency: a frame's result is presented the cycle after its last byte is accepted.
// Throughput: one byte per cycle while in_ready_o is high; every byte passes through one register stage.
// in_ready_o drops only while a result waits in the output register and is not taken.
// Reset (rst_ni low, async): frame state and output valid clear, config regs take
// their defaults (mic 1, camera 2, speaker 3, audio length 512, JPEG max 65536).
`include "media_frame_decoder_validator_assert.svh"

module media_frame_decoder_validator
  import mfdv_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // byte stream in
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   frame_end_i,
  // frame results out
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [TYPE_W-1:0]      frame_type_o,
  output logic [COUNTER_W-1:0]   frame_counter_o,
  output logic [LEN_FIELD_W-1:0] payload_len_o,
  output logic                   type_known_o,
  output logic [1:0]             status_o
);

  localparam int unsigned CmpW = (LENGTH_BITS > LEN_FIELD_W) ? LENGTH_BITS : LEN_FIELD_W;
  localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mic_type  <= 8'd1;
      cfg_q.cam_type  <= 8'd2;
      cfg_q.spk_type  <= 8'd3;
      cfg_q.audio_len <= 20'd512;
      cfg_q.jpeg_max  <= 20'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIC_TYPE:  cfg_q.mic_type  <= cfg_data_i[TYPE_W-1:0];
        CFG_CAM_TYPE:  cfg_q.cam_type  <= cfg_data_i[TYPE_W-1:0];
        CFG_SPK_TYPE:  cfg_q.spk_type  <= cfg_data_i[TYPE_W-1:0];
        CFG_AUDIO_LEN: cfg_q.audio_len <= cfg_data_i[LEN_FIELD_W-1:0];
        CFG_JPEG_MAX:  cfg_q.jpeg_max  <= cfg_data_i[LEN_FIELD_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state
  //   hdr_cnt_q counts header bytes (0..5); once at 5, payload bytes go to cnt_q.
  // ---------------------------------------------------------------------------
  logic [2:0]             hdr_cnt_q, hdr_cnt_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic [TYPE_W-1:0]      type_q, type_d;
  logic [COUNTER_W-1:0]   counter_q, counter_d;
  marks_t                 marks_q, marks_d;

  logic in_xact;
  logic frame_done;

  // A result slot must be free (or freeing) before any byte is taken.
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_xact    = in_valid_i && in_ready_o;
  assign frame_done = in_xact && frame_end_i;

  // Per-byte update; the result below is judged on these updated values.
  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    cnt_d     = cnt_q;
    type_d    = type_q;
    counter_d = counter_q;
    marks_d   = marks_q;
    if (hdr_cnt_q == 3'd0) begin
      type_d    = data_byte_i;
      hdr_cnt_d = 3'd1;
    end else if (hdr_cnt_q < HDR_BYTES) begin
      // little-endian: header byte n lands in counter lane n-1
      counter_d = counter_q | ({24'd0, data_byte_i} << {hdr_cnt_q - 3'd1, 3'b000});
      hdr_cnt_d = hdr_cnt_q + 3'd1;
    end else begin
      if ((cnt_q == '0) && (data_byte_i == JPEG_MARK)) begin
        marks_d.start_ok[0] = 1'b1;
      end
      if ((cnt_q == LENGTH_BITS'(1)) && (data_byte_i == JPEG_SOI)) begin
        marks_d.start_ok[1] = 1'b1;
      end
      marks_d.last_two = {marks_q.last_two[7:0], data_byte_i};
      // saturate: a byte arriving at the max count flags overflow instead
      if (cnt_q == LenMax) begin
        marks_d.len_ovf = 1'b1;
      end else begin
        cnt_d = cnt_q + LENGTH_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      cnt_q     <= '0;
      type_q    <= '0;
      counter_q <= '0;
      marks_q   <= '0;
    end else if (frame_done) begin
      // last byte: clear for the next frame
      hdr_cnt_q <= '0;
      cnt_q     <= '0;
      type_q    <= '0;
      counter_q <= '0;
      marks_q   <= '0;
    end else if (in_xact) begin
      hdr_cnt_q <= hdr_cnt_d;
      cnt_q     <= cnt_d;
      type_q    <= type_d;
      counter_q <= counter_d;
      marks_q   <= marks_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Classification of the completed frame
  // ---------------------------------------------------------------------------
  logic    known;
  status_e cls_status;
  logic    truncated;
  logic [CmpW-1:0] len_w;

  mfdv_classify #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_classify (
    .cfg_i        (cfg_q),
    .frame_type_i (type_d),
    .len_i        (cnt_d),
    .marks_i      (marks_d),
    .type_known_o (known),
    .status_o     (cls_status)
  );

  assign truncated = (hdr_cnt_d < HDR_BYTES);
  assign len_w     = CmpW'(cnt_d);

  // ---------------------------------------------------------------------------
  // Output register: one result per frame, held until taken
  // ---------------------------------------------------------------------------
  logic                   out_valid_q;
  logic [TYPE_W-1:0]      out_type_q;
  logic [COUNTER_W-1:0]   out_counter_q;
  logic [LEN_FIELD_W-1:0] out_len_q;
  logic                   out_known_q;
  status_e                out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // A truncated frame reports only its status; all other fields read zero.
  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      if (truncated) begin
        out_type_q    <= '0;
        out_counter_q <= '0;
        out_len_q     <= '0;
        out_known_q   <= 1'b0;
        out_status_q  <= ST_TRUNC;
      end else begin
        out_type_q    <= type_d;
        out_counter_q <= counter_d;
        out_len_q     <= len_w[LEN_FIELD_W-1:0];
        out_known_q   <= known;
        out_status_q  <= cls_status;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_type_o    = out_type_q;
  assign frame_counter_o = out_counter_q;
  assign payload_len_o   = out_len_q;
  assign type_known_o    = out_known_q;
  assign status_o        = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Every frame end yields a pending result next cycle.
  `MFDV_ASSERT_NEXT(a_result_follows_end, frame_done, out_valid_o)
  // Frame state is back to empty right after a frame end.
  `MFDV_ASSERT_NEXT(a_state_cleared, frame_done, (hdr_cnt_q == 3'd0) && (cnt_q == '0))
  // Payload bytes are only counted once the header is complete.
  `MFDV_ASSERT_NOW(a_no_count_in_hdr, hdr_cnt_q < HDR_BYTES, cnt_q == '0)
  // Overflow is only flagged with the count pinned at its maximum.
  `MFDV_ASSERT_NOW(a_ovf_at_max, marks_q.len_ovf, cnt_q == LenMax)

endmodule

/* verif/media_frame_decoder_validator_checker.sv */
`timescale 1ns / 1ps
// Checker: watches config, byte and result channels, predicts each frame result and compares.
module media_frame_decoder_validator_checker
  import mfdv_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   frame_end_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [TYPE_W-1:0]      frame_type_i,
  input  logic [COUNTER_W-1:0]   frame_counter_i,
  input  logic [LEN_FIELD_W-1:0] payload_len_i,
  input  logic                   type_known_i,
  input  logic [1:0]             status_i,
  output int                     error_count_o,
  output int                     pending_o
);

  localparam logic [LENGTH_BITS:0] LEN_MAX = {1'b0, {LENGTH_BITS{1'b1}}};

  typedef struct packed {
    logic [TYPE_W-1:0]      ftype;
    logic [COUNTER_W-1:0]   counter;
    logic [LEN_FIELD_W-1:0] plen;
    logic                   known;
    status_e                status;
  } frame_result_t;

  // register shadow and per-frame decode state
  cfg_t                 regs;
  logic [LENGTH_BITS:0] pos;
  logic [TYPE_W-1:0]    held_type;
  logic [COUNTER_W-1:0] held_counter;
  marks_t               marks;

  frame_result_t frame_results_q[$];

  task automatic clear_frame_state();
    pos          = '0;
    held_type    = '0;
    held_counter = '0;
    marks        = '0;
  endtask

  // Advance the frame state by one byte; on the last byte queue the expected result.
  task automatic decode_byte(input logic [7:0] b, input logic is_last);
    frame_result_t        res;
    logic [LENGTH_BITS:0] idx;
    logic                 is_audio;
    logic                 is_cam;
    res = '0;
    if (pos == 0) begin
      held_type = b;
      pos = (LENGTH_BITS + 1)'(1);
    end else if (pos < HDR_BYTES) begin
      held_counter[8*(pos-1) +: 8] = b;
      pos++;
    end else begin
      idx = pos - HDR_BYTES;
      if (idx == 0 && b == JPEG_MARK) marks.start_ok[0] = 1'b1;
      if (idx == 1 && b == JPEG_SOI) marks.start_ok[1] = 1'b1;
      marks.last_two = {marks.last_two[7:0], b};
      if (idx >= LEN_MAX) marks.len_ovf = 1'b1;
      else pos++;
    end
    if (is_last) begin
      if (pos < HDR_BYTES) begin
        res.status = ST_TRUNC;
      end else begin
        idx      = pos - HDR_BYTES;
        is_audio = (held_type == regs.mic_type) || (held_type == regs.spk_type);
        is_cam   = (held_type == regs.cam_type);
        res.status = ST_OK;
        // saturation wins over everything, audio wins over camera
        if (marks.len_ovf) begin
          res.status = ST_LEN_ERR;
        end else if (is_audio) begin
          res.status = (idx == regs.audio_len) ? ST_OK : ST_LEN_ERR;
        end else if (is_cam) begin
          if (idx > regs.jpeg_max) begin
            res.status = ST_LEN_ERR;
          end else if (idx < JPEG_MIN_LEN || marks.start_ok != 2'b11 ||
                       marks.last_two != JPEG_EOI_WORD) begin
            res.status = ST_FMT_ERR;
          end
        end
        res.ftype   = held_type;
        res.counter = held_counter;
        res.plen    = idx[LEN_FIELD_W-1:0];
        res.known   = is_audio || is_cam;
      end
      frame_results_q.push_back(res);
      clear_frame_state();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      regs.mic_type  = 8'd1;
      regs.cam_type  = 8'd2;
      regs.spk_type  = 8'd3;
      regs.audio_len = 20'd512;
      regs.jpeg_max  = 20'd65536;
      clear_frame_state();
      frame_results_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIC_TYPE:  regs.mic_type  = cfg_data_i[TYPE_W-1:0];
          CFG_CAM_TYPE:  regs.cam_type  = cfg_data_i[TYPE_W-1:0];
          CFG_SPK_TYPE:  regs.spk_type  = cfg_data_i[TYPE_W-1:0];
          CFG_AUDIO_LEN: regs.audio_len = cfg_data_i[LEN_FIELD_W-1:0];
          CFG_JPEG_MAX:  regs.jpeg_max  = cfg_data_i[LEN_FIELD_W-1:0];
          default: ;
        endcase
      end
      // results leave no earlier than the cycle after their last byte, so pop first
      if (out_valid_i && out_ready_i) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual type %0h counter %0h",
                   $time, frame_type_i, frame_counter_i);
          error_count_o++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("frame_type", want.ftype, frame_type_i);
          check_field("frame_counter", want.counter, frame_counter_i);
          check_field("payload_len", want.plen, payload_len_i);
          check_field("type_known", want.known, type_known_i);
          check_field("status", want.status, status_i);
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(data_byte_i, frame_end_i);
      pending_o <= frame_results_q.size();
    end
  end

endmodule

/* verif/media_frame_decoder_validator_tb.sv */
`timescale 1ns / 1ps
// Testbench top: byte-stream stimulus, register phases and verdict for the frame decoder.
module media_frame_decoder_validator_tb;
  import mfdv_pkg::*;

  localparam int unsigned LENGTH_BITS    = 20;
  localparam int unsigned LEN_MAX        = (1 << LENGTH_BITS) - 1;
  // slowest legal run: some 600 bytes, each one a frame end held by a sparse
  // receiver, plus sender gaps and the hold-off; taken many times over
  localparam int unsigned CYCLE_LIMIT    = 100_000;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned HOLDOFF_AT     = 25;
  localparam int unsigned PHASE_BYTES    = 80;
  localparam int unsigned PHASE_FRAMES   = 8;
  localparam int unsigned NUM_SETTINGS   = 6;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE} rx_mode_e;
  typedef enum logic [2:0] {FR_TRUNC, FR_AUDIO, FR_JPEG, FR_ANY, FR_HDR_ONLY} frame_kind_e;

  // every DUT input holds a known value from time zero
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic [7:0]             data_byte  = '0;
  logic                   frame_end  = 1'b0;
  logic                   out_ready  = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic [TYPE_W-1:0]      frame_type;
  logic [COUNTER_W-1:0]   frame_counter;
  logic [LEN_FIELD_W-1:0] payload_len;
  logic                   type_known;
  logic [1:0]             status;
  int                     error_count;
  int                     pending;

  // stimulus bookkeeping
  logic [7:0]             frame_bytes[$];
  int unsigned            bytes_sent  = 0;
  int unsigned            frames_sent = 0;
  int unsigned            burst_left  = 0;
  int unsigned            cycle_count = 0;

  // register values currently programmed, used to shape well-formed frames
  logic [TYPE_W-1:0]      cur_mic   = 8'd1;
  logic [TYPE_W-1:0]      cur_cam   = 8'd2;
  logic [TYPE_W-1:0]      cur_spk   = 8'd3;
  logic [LEN_FIELD_W-1:0] cur_audio = 20'd512;
  logic [LEN_FIELD_W-1:0] cur_jpeg  = 20'd65536;

  // receiver state
  rx_mode_e               rx_mode      = RX_ALWAYS;
  int unsigned            rx_mode_left = 0;
  int unsigned            holdoff_left = 0;
  logic                   held_once    = 1'b0;
  int unsigned            results_seen = 0;

  media_frame_decoder_validator #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .frame_end_i    (frame_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .frame_type_o   (frame_type),
    .frame_counter_o(frame_counter),
    .payload_len_o  (payload_len),
    .type_known_o   (type_known),
    .status_o       (status)
  );

  media_frame_decoder_validator_checker #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .data_byte_i    (data_byte),
    .frame_end_i    (frame_end),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .frame_type_i   (frame_type),
    .frame_counter_i(frame_counter),
    .payload_len_i  (payload_len),
    .type_known_i   (type_known),
    .status_i       (status),
    .error_count_o  (error_count),
    .pending_o      (pending)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, pending);
      $display("FAIL media_frame_decoder_validator");
      $finish;
    end
  end

  // Receiver: switches between always-ready, coin-flip and sparse stretches.
  // Once, after some results, it holds off for a long stretch so the output
  // register fills and the block backs up onto the byte input.
  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen++;
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else if (!held_once && results_seen == HOLDOFF_AT) begin
      held_once    = 1'b1;
      holdoff_left = HOLDOFF_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(20, 80);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Bytes skewed toward the JPEG marker values and the extremes.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return JPEG_MARK;
      1:       return JPEG_SOI;
      2:       return JPEG_EOI_WORD[7:0];
      3:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one byte and hold it until it is taken. Bursts end in random gaps,
  // and about a quarter of bursts run straight into the next one.
  task automatic push_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    in_valid  <= 1'b1;
    data_byte <= b;
    frame_end <= is_last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    frames_sent++;
  endtask

  // Wait until every frame result is back, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Type codes go out with junk in the unused upper bits.
  task automatic write_code(input logic [CFG_IDX_W-1:0] idx, input logic [TYPE_W-1:0] code);
    logic [CFG_DATA_W-1:0] val;
    val = CFG_DATA_W'($urandom);
    val[TYPE_W-1:0] = code;
    write_reg(idx, val);
  endtask

  task automatic apply_setting(input int unsigned k);
    logic [TYPE_W-1:0] shared;
    shared = TYPE_W'($urandom_range(0, 255));
    case (k)
      1: begin  // low extremes: zero lengths
        cur_mic = 8'd0;   cur_cam = 8'd255; cur_spk = 8'd128;
        cur_audio = '0;   cur_jpeg = '0;
      end
      2: begin  // high extremes, mic and speaker share a code
        cur_mic = 8'd255; cur_cam = 8'd0;   cur_spk = 8'd255;
        cur_audio = LEN_FIELD_W'(LEN_MAX); cur_jpeg = LEN_FIELD_W'(LEN_MAX);
      end
      3: begin  // camera code overlaps mic code: audio must win
        cur_mic = shared; cur_cam = shared; cur_spk = shared ^ 8'h01;
        cur_audio = LEN_FIELD_W'($urandom_range(0, 12));
        cur_jpeg  = LEN_FIELD_W'($urandom_range(4, 16));
      end
      4: begin
        cur_mic = TYPE_W'($urandom_range(0, 255)); cur_cam = TYPE_W'($urandom_range(0, 255));
        cur_spk = TYPE_W'($urandom_range(0, 255));
        cur_audio = LEN_FIELD_W'($urandom_range(0, 20));
        cur_jpeg  = LEN_FIELD_W'($urandom_range(0, 30));
      end
      default: begin  // audio length at the ceiling, speaker code random
        cur_mic = TYPE_W'($urandom_range(0, 255)); cur_cam = TYPE_W'($urandom_range(0, 255));
        cur_spk = shared;
        cur_audio = LEN_FIELD_W'(LEN_MAX); cur_jpeg = LEN_FIELD_W'($urandom_range(0, 40));
      end
    endcase
    write_code(CFG_MIC_TYPE, cur_mic);
    write_code(CFG_CAM_TYPE, cur_cam);
    write_code(CFG_SPK_TYPE, cur_spk);
    write_reg(CFG_AUDIO_LEN, cur_audio);
    write_reg(CFG_JPEG_MAX, cur_jpeg);
    // an index past the register file must be ignored
    write_reg(CFG_IDX_W'($urandom_range(CFG_JPEG_MAX + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_frame();
    frame_kind_e       kind;
    int unsigned       plen;
    logic [TYPE_W-1:0] ftype;
    kind = frame_kind_e'($urandom_range(0, 4));
    frame_bytes.delete();
    plen = 0;
    case (kind)
      FR_AUDIO: begin
        ftype = $urandom_range(0, 1) ? cur_mic : cur_spk;
        plen  = (cur_audio <= 40) ? cur_audio : $urandom_range(0, 20);
        case ($urandom_range(0, 3))
          0:       plen = plen + 1;
          1:       if (plen > 0) plen = plen - 1;
          default: ;
        endcase
      end
      FR_JPEG: begin
        ftype = cur_cam;
        case ($urandom_range(0, 3))
          0:       plen = $urandom_range(0, 3);
          1:       plen = (cur_jpeg <= 40) ? cur_jpeg + $urandom_range(0, 1)
                                           : $urandom_range(4, 24);
          default: plen = $urandom_range(4, 24);
        endcase
      end
      FR_HDR_ONLY: begin
        case ($urandom_range(0, 2))
          0:       ftype = cur_mic;
          1:       ftype = cur_cam;
          default: ftype = cur_spk;
        endcase
      end
      default: begin
        ftype = rand_byte();
        plen  = $urandom_range(0, 24);
      end
    endcase
    if (kind == FR_TRUNC) begin
      // under five bytes: no complete header
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(rand_byte());
    end else begin
      frame_bytes.push_back(ftype);
      repeat (4) frame_bytes.push_back(rand_byte());
      repeat (plen) frame_bytes.push_back(rand_byte());
      if (kind == FR_JPEG && plen >= 2) begin
        frame_bytes[5]        = JPEG_MARK;
        frame_bytes[6]        = JPEG_SOI;
        frame_bytes[plen + 3] = JPEG_EOI_WORD[15:8];
        frame_bytes[plen + 4] = JPEG_EOI_WORD[7:0];
        // now and then overwrite one random payload byte, which may hit a marker
        if ($urandom_range(0, 3) == 0) begin
          frame_bytes[5 + $urandom_range(0, plen - 1)] = 8'($urandom);
        end
      end
    end
    send_frame();
  endtask

  initial begin
    int unsigned phase_bytes;
    int unsigned phase_frames;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames with the reset register values.
    // A lone byte, then four bytes: both truncated.
    frame_bytes = '{8'hFF};
    send_frame();
    frame_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF};
    send_frame();
    // Header only, mic type, all-ones counter: audio length mismatch.
    frame_bytes = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    // Smallest good JPEG: FF D8 FF D9.
    frame_bytes = '{8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hD8, 8'hFF, 8'hD9};
    send_frame();
    // JPEG one byte short of the minimum: format error.
    frame_bytes = '{8'h02, 8'h78, 8'h56, 8'h34, 8'h12, 8'hFF, 8'hD8, 8'hD9};
    send_frame();

    // Random phases, one register setting each; phase 0 keeps the reset values.
    for (int unsigned k = 0; k < NUM_SETTINGS; k++) begin
      drain();
      if (k != 0) apply_setting(k);
      phase_bytes  = bytes_sent;
      phase_frames = frames_sent;
      while (bytes_sent - phase_bytes < PHASE_BYTES ||
             frames_sent - phase_frames < PHASE_FRAMES) begin
        send_random_frame();
      end
    end
    drain();

    $display("Covered %0d frames over %0d bytes in %0d register settings,",
             frames_sent, bytes_sent, NUM_SETTINGS);
    $display("incl. truncated, audio and JPEG frames and a %0d-cycle output hold-off.",
             HOLDOFF_CYCLES);
    if (error_count == 0) begin
      $display("PASS media_frame_decoder_validator");
    end else begin
      $display("FAIL media_frame_decoder_validator");
    end
    $finish;
  end

endmodule
